// ===== hdl/bmt_pkg.sv =====
package bmt_pkg;

  localparam int unsigned MutexIdW   = 8;
  localparam int unsigned TaskIdW    = 4;
  localparam int unsigned WakeW      = 16;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 24;

  typedef enum logic [1:0] {
    CMD_LOCK     = 2'd0,
    CMD_TRY_LOCK = 2'd1,
    CMD_UNLOCK   = 2'd2,
    CMD_GET      = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BUSY       = 3'd1,
    ST_BLOCKED    = 3'd2,
    ST_INVALID    = 3'd3,
    ST_DEADLOCK   = 3'd4,
    ST_NOT_HOLDER = 3'd5
  } status_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic                 mutex_ok;
    logic                 task_ok;
    logic [MutexIdW-1:0]  mutex_id;
    logic [TaskIdW-1:0]   task_id;
  } req_t;

  typedef struct packed {
    logic [WakeW-1:0]     wake_mask;
    logic [TaskIdW-1:0]   holder_task;
    logic                 holder_valid;
    status_e              status;
  } res_t;

endpackage

// ===== hdl/bmt_front.sv =====
module bmt_front import bmt_pkg::*; #(
  parameter int unsigned NUM_MUTEXES = 16,
  parameter int unsigned NUM_TASKS   = 16
) (
  input  logic [1:0]          cmd_i,
  input  logic [MutexIdW-1:0] mutex_id_i,
  input  logic [TaskIdW-1:0]  task_id_i,
  output req_t                req_o
);

  always_comb begin
    req_o.cmd      = cmd_e'(cmd_i);
    req_o.mutex_id = mutex_id_i;
    req_o.task_id  = task_id_i;
    req_o.mutex_ok = (32'(mutex_id_i) < NUM_MUTEXES);
    req_o.task_ok  = (32'(task_id_i) < NUM_TASKS);
  end

endmodule

// ===== hdl/bmt_fifo.sv =====
module bmt_fifo import bmt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output req_t head_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  req_t            entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/bmt_back.sv =====
module bmt_back import bmt_pkg::*; #(
  parameter int unsigned NUM_MUTEXES = 16,
  parameter int unsigned NUM_TASKS   = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  req_t req_i,
  output logic req_pop_o,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  localparam int unsigned MW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
  localparam int unsigned WT = (NUM_TASKS < WakeW) ? NUM_TASKS : WakeW;

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_EXEC = 2'b10
  } bk_state_e;

  bk_state_e          state_q, state_d;
  req_t               req_q;
  logic [TaskIdW-1:0] rd_q;
  logic [TaskIdW-1:0] holder_mem [NUM_MUTEXES];

  logic [NUM_MUTEXES-1:0] held_q, held_d;
  logic [WT-1:0]          waiting_q, waiting_d;
  logic [MW-1:0]          waited_q [WT];
  logic [MW-1:0]          waited_d [WT];

  logic          out_valid_q;
  res_t          out_q, res_d;
  logic          fire;
  logic          mem_we;
  logic [MW-1:0] mi;
  logic [MW-1:0] head_mi;
  logic          held;
  logic          is_owner;
  logic          grant;
  logic          release_m;
  logic          held_after;
  logic [WakeW-1:0] wake;

  assign mi       = req_q.mutex_id[MW-1:0];
  assign head_mi  = req_i.mutex_id[MW-1:0];
  assign held     = held_q[mi];
  assign is_owner = held && (rd_q == req_q.task_id);
  assign fire     = (state_q == BK_EXEC) && (!out_valid_q || res_ready_i);

  assign req_pop_o   = (state_q == BK_IDLE) && req_valid_i;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (req_valid_i) begin
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (fire) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    held_d    = held_q;
    waiting_d = waiting_q;
    waited_d  = waited_q;
    mem_we    = 1'b0;
    grant     = 1'b0;
    release_m = 1'b0;
    wake      = '0;
    res_d.status = ST_OK;

    if (!req_q.mutex_ok) begin
      res_d.status = ST_INVALID;
    end else if (req_q.cmd != CMD_GET && !req_q.task_ok) begin
      res_d.status = ST_INVALID;
    end else begin
      unique case (req_q.cmd)
        CMD_LOCK: begin
          if (is_owner) begin
            res_d.status = ST_DEADLOCK;
          end else if (!held) begin
            grant = 1'b1;
          end else begin
            for (int i = 0; i < WT; i++) begin
              if (req_q.task_id == TaskIdW'(i)) begin
                waiting_d[i] = 1'b1;
                waited_d[i]  = mi;
              end
            end
            res_d.status = ST_BLOCKED;
          end
        end
        CMD_TRY_LOCK: begin
          if (!held) begin
            grant = 1'b1;
          end else begin
            res_d.status = ST_BUSY;
          end
        end
        CMD_UNLOCK: begin
          if (!is_owner) begin
            res_d.status = ST_NOT_HOLDER;
          end else begin
            release_m = 1'b1;
            for (int i = 0; i < WT; i++) begin
              if (waiting_q[i] && waited_q[i] == mi) begin
                waiting_d[i] = 1'b0;
                wake[i]      = 1'b1;
              end
            end
          end
        end
        CMD_GET: res_d.status = ST_OK;
        default: res_d.status = ST_OK;
      endcase
    end

    if (grant) begin
      held_d[mi] = 1'b1;
      mem_we     = 1'b1;
    end
    if (release_m) begin
      held_d[mi] = 1'b0;
    end

    held_after         = req_q.mutex_ok && (grant || (held && !release_m));
    res_d.holder_valid = held_after;
    res_d.holder_task  = grant ? req_q.task_id : (held_after ? rd_q : '0);
    res_d.wake_mask    = wake;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      held_q      <= '0;
      waiting_q   <= '0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        out_valid_q <= 1'b1;
        held_q      <= held_d;
        waiting_q   <= waiting_d;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      req_q <= req_i;
    end
    if (fire) begin
      out_q    <= res_d;
      waited_q <= waited_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && mem_we) begin
      holder_mem[mi] <= req_q.task_id;
    end
    if (req_pop_o && req_i.mutex_ok) begin
      rd_q <= holder_mem[head_mi];
    end
  end

endmodule

// ===== hdl/blocking_mutex_table.sv =====
// Mutex table with waiter wakeup. Each request word carries a command (lock, try lock,
// unlock, get holder), a mutex id and the requesting task id; each request returns exactly
// one result word with a status, the mutex holder after the request and, on a successful
// unlock, the mask of waiting tasks released. Requests enter a two-word queue and are
// executed one at a time: each request first reads the holder memory as it is taken from
// the queue, and then updates the table and loads the result register; the next request
// is not taken until that load. A result waiting on the output does not stop the next
// request from being read, but the update for that request waits until the result is
// taken. Only tasks 0 to 15 can wait on a mutex.
module blocking_mutex_table import bmt_pkg::*; #(
  parameter int unsigned NUM_MUTEXES = 16,
  parameter int unsigned NUM_TASKS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [1:0] cmd, [9:2] mutex_id, [13:10] task_id, [15:14] zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [2:0] status, [3] holder_valid, [7:4] holder_task, [23:8] wake_mask
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  req_t front_req;
  req_t head;
  res_t res;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic push;

  assign s_axis_tready_o = !q_full;
  assign push            = s_axis_tvalid_i && !q_full;

  bmt_front #(
    .NUM_MUTEXES(NUM_MUTEXES),
    .NUM_TASKS  (NUM_TASKS)
  ) u_front (
    .cmd_i     (s_axis_tdata_i[1:0]),
    .mutex_id_i(s_axis_tdata_i[9:2]),
    .task_id_i (s_axis_tdata_i[13:10]),
    .req_o     (front_req)
  );

  bmt_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(front_req),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (head)
  );

  bmt_back #(
    .NUM_MUTEXES(NUM_MUTEXES),
    .NUM_TASKS  (NUM_TASKS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(!q_empty),
    .req_i      (head),
    .req_pop_o  (q_pop),
    .res_valid_o(m_axis_tvalid_o),
    .res_ready_i(m_axis_tready_i),
    .res_o      (res)
  );

  assign m_axis_tdata_o = res;

  a_wake_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (res.wake_mask != '0) |-> res.status == ST_OK)
    else $error("wake mask on a failed request");

  a_holder_zero_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !res.holder_valid |-> res.holder_task == '0)
    else $error("holder task reported for a free mutex");

  a_blocked_means_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.status == ST_BLOCKED |-> res.holder_valid)
    else $error("blocked on a free mutex");

endmodule
